FILE: design/clt_pkg.sv
// Shared types and character constants for the command-line tokenizer.
`default_nettype none

package clt_pkg;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       token_end;
      logic       command_end;
   } result_type;

endpackage

`default_nettype wire

FILE: design/command_line_tokenizer.sv
// Command-line tokenizer: splits a zero-terminated byte stream into tokens.
//
// Channel   Dir   Handshake                 Contents
// req_      in    req_tvalid / req_tready   tdata: in_byte
// rsp_      out   rsp_tvalid / rsp_tready   tdata: out_byte, tuser: byte_valid, token_end,
//                                           tlast: command_end
//
// One input word is taken per cycle while the buffer has room; the parser state updates in the cycle it is accepted.
// Each input word yields zero, one or two result words, queued in a four-word buffer.
// The input stalls only when more than two result words are waiting.
// Reset is synchronous and returns the parser to skipping leading spaces with an empty buffer.
`default_nettype none

module command_line_tokenizer
   import clt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [1:0]      rsp_tuser,   // [0] byte_valid, [1] token_end
   output logic            rsp_tlast    // command_end
);

   typedef enum logic [1:0] {
      MODE_SKIP    = 2'd0,
      MODE_BARE    = 2'd1,
      MODE_QUOTED  = 2'd2,
      MODE_DISCARD = 2'd3
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic       bs_ff, bs_in;
   logic [1:0] pos_ff, pos_in;
   logic       started_ff, started_in;

   result_type fifo_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;

   result_type res [2];
   logic [1:0] n_res;
   logic       accept, pop;

   assign req_tready = (count_ff <= 3'd2);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != 3'd0);
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      logic [7:0] b;
      logic       cont;
      logic       bs_cur;
      logic [1:0] pos_cur;
      logic [7:0] term;
      b          = req_tdata;
      cont       = 1'b0;
      bs_cur     = bs_ff;
      pos_cur    = pos_ff;
      mode_in    = mode_ff;
      bs_in      = bs_ff;
      pos_in     = pos_ff;
      started_in = started_ff;
      n_res      = 2'd0;
      res[0]     = '0;
      res[1]     = '0;
      term       = (mode_ff == MODE_BARE) ? CH_SPACE : CH_QUOTE;
      unique case (mode_ff)
         MODE_SKIP: begin
            if (b == CH_NUL) begin
               res[0]     = '{CH_NUL, 1'b0, started_ff, 1'b1};
               n_res      = 2'd1;
               mode_in    = MODE_SKIP;
               bs_in      = 1'b0;
               pos_in     = 2'd0;
               started_in = 1'b0;
            end else if (b == CH_SPACE) begin
               started_in = 1'b1;
            end else if (b == CH_QUOTE) begin
               started_in = 1'b1;
               mode_in    = MODE_QUOTED;
               pos_in     = 2'd0;
               bs_in      = 1'b0;
            end else begin
               started_in = 1'b1;
               mode_in    = MODE_BARE;
               bs_cur     = 1'b0;
               pos_cur    = 2'd0;
               cont       = 1'b1;
            end
         end
         MODE_BARE, MODE_QUOTED: begin
            if (b == CH_NUL) begin
               res[0]     = bs_ff ? result_type'{CH_BSLASH, 1'b1, 1'b1, 1'b1}
                                  : result_type'{CH_NUL, 1'b0, 1'b1, 1'b1};
               n_res      = 2'd1;
               mode_in    = MODE_SKIP;
               bs_in      = 1'b0;
               pos_in     = 2'd0;
               started_in = 1'b0;
            end else if (b == term && (pos_ff == 2'd1 || !bs_ff)) begin
               res[0]  = bs_ff ? result_type'{CH_BSLASH, 1'b1, 1'b1, 1'b0}
                               : result_type'{CH_NUL, 1'b0, 1'b1, 1'b0};
               n_res   = 2'd1;
               bs_in   = 1'b0;
               mode_in = (mode_ff == MODE_BARE) ? MODE_SKIP : MODE_DISCARD;
               pos_in  = 2'd0;
            end else begin
               cont = 1'b1;
            end
         end
         MODE_DISCARD: begin
            if (b == CH_NUL) begin
               res[0]     = '{CH_NUL, 1'b0, 1'b0, 1'b1};
               n_res      = 2'd1;
               mode_in    = MODE_SKIP;
               bs_in      = 1'b0;
               pos_in     = 2'd0;
               started_in = 1'b0;
            end else if (b == CH_SPACE) begin
               mode_in = MODE_SKIP;
            end
         end
         default: begin
            mode_in = MODE_SKIP;
         end
      endcase
      if (cont) begin
         if (bs_cur) begin
            if (b == CH_QUOTE || b == CH_SPACE) begin
               res[0] = '{b, 1'b1, 1'b0, 1'b0};
               n_res  = 2'd1;
               bs_in  = 1'b0;
            end else begin
               res[0] = '{CH_BSLASH, 1'b1, 1'b0, 1'b0};
               if (b == CH_BSLASH) begin
                  n_res = 2'd1;
                  bs_in = 1'b1;
               end else begin
                  res[1] = '{b, 1'b1, 1'b0, 1'b0};
                  n_res  = 2'd2;
                  bs_in  = 1'b0;
               end
            end
         end else if (b == CH_BSLASH) begin
            bs_in = 1'b1;
         end else begin
            res[0] = '{b, 1'b1, 1'b0, 1'b0};
            n_res  = 2'd1;
            bs_in  = 1'b0;
         end
         pos_in = (pos_cur < 2'd2) ? pos_cur + 2'd1 : pos_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SKIP;
         bs_ff      <= 1'b0;
         pos_ff     <= 2'd0;
         started_ff <= 1'b0;
         wr_ptr_ff  <= 2'd0;
         rd_ptr_ff  <= 2'd0;
         count_ff   <= 3'd0;
      end else begin
         if (accept) begin
            mode_ff    <= mode_in;
            bs_ff      <= bs_in;
            pos_ff     <= pos_in;
            started_ff <= started_in;
            wr_ptr_ff  <= wr_ptr_ff + n_res;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (accept && n_res != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res[0];
      end
      if (accept && n_res == 2'd2) begin
         fifo_ff[wr_ptr_ff + 2'd1] <= res[1];
      end
   end

   assign rsp_tdata    = fifo_ff[rd_ptr_ff].out_byte;
   assign rsp_tuser[0] = fifo_ff[rd_ptr_ff].byte_valid;
   assign rsp_tuser[1] = fifo_ff[rd_ptr_ff].token_end;
   assign rsp_tlast    = fifo_ff[rd_ptr_ff].command_end;

endmodule

`default_nettype wire

FILE: design/clt_checker.sv
// Port-level checks for the command-line tokenizer, bound to the top level.
`default_nettype none

module clt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // A word without a character carries a zero byte.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'h00)
      else $error("empty word with non-zero byte");

   // A word without a character always marks the end of a token or command.
   a_empty_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[1] || rsp_tlast)
      else $error("empty word without an end mark");

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");

   // The input is held off only while result words are backed up.
   a_ready_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the command-line tokenizer, with randomised traffic and stalls.
`timescale 1ns / 100ps

module testbench;
   import clt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int STIMULUS_WORDS = 430;

   typedef enum logic [1:0] {
      SKIP_SPACES,
      BARE_TOKEN,
      QUOTED_TOKEN,
      DISCARD_TO_SPACE
   } parse_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   logic [7:0] pending_bytes[$];
   result_type due_results[$];

   parse_mode_type tok_mode = SKIP_SPACES;
   logic held_bslash = 1'b0;
   logic [1:0] content_pos = 2'd0;
   logic line_started = 1'b0;

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;
   int unsigned req_wait = 0;
   int unsigned rsp_stall = 0;
   int unsigned words_in = 0;
   int unsigned hold_left = 0;
   logic hold_done = 1'b0;
   int unsigned cycles = 0;
   int unsigned fails = 0;

   command_line_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void emit(logic [7:0] b, logic v, logic te, logic ce);
      result_type r;
      r.out_byte = b;
      r.byte_valid = v;
      r.token_end = te;
      r.command_end = ce;
      due_results.push_back(r);
   endfunction

   function automatic void clear_parser();
      tok_mode = SKIP_SPACES;
      held_bslash = 1'b0;
      content_pos = 2'd0;
      line_started = 1'b0;
   endfunction

   function automatic void close_token(logic ce);
      if (held_bslash) begin
         emit(CH_BSLASH, 1'b1, 1'b1, ce);
      end else begin
         emit(CH_NUL, 1'b0, 1'b1, ce);
      end
      held_bslash = 1'b0;
   endfunction

   function automatic void take_content(logic [7:0] b);
      if (held_bslash) begin
         if (b == CH_QUOTE || b == CH_SPACE) begin
            emit(b, 1'b1, 1'b0, 1'b0);
            held_bslash = 1'b0;
         end else begin
            emit(CH_BSLASH, 1'b1, 1'b0, 1'b0);
            if (b == CH_BSLASH) begin
               held_bslash = 1'b1;
            end else begin
               emit(b, 1'b1, 1'b0, 1'b0);
               held_bslash = 1'b0;
            end
         end
      end else if (b == CH_BSLASH) begin
         held_bslash = 1'b1;
      end else begin
         emit(b, 1'b1, 1'b0, 1'b0);
      end
      if (content_pos < 2'd2) content_pos = content_pos + 2'd1;
   endfunction

   function automatic void tokenize_byte(logic [7:0] b);
      logic [7:0] closer;
      case (tok_mode)
         SKIP_SPACES: begin
            if (b == CH_NUL) begin
               emit(CH_NUL, 1'b0, line_started, 1'b1);
               clear_parser();
            end else if (b == CH_SPACE) begin
               line_started = 1'b1;
            end else begin
               line_started = 1'b1;
               content_pos = 2'd0;
               held_bslash = 1'b0;
               if (b == CH_QUOTE) begin
                  tok_mode = QUOTED_TOKEN;
               end else begin
                  tok_mode = BARE_TOKEN;
                  take_content(b);
               end
            end
         end
         BARE_TOKEN, QUOTED_TOKEN: begin
            closer = (tok_mode == BARE_TOKEN) ? CH_SPACE : CH_QUOTE;
            if (b == CH_NUL) begin
               close_token(1'b1);
               clear_parser();
            end else if (b == closer && (content_pos == 2'd1 || !held_bslash)) begin
               close_token(1'b0);
               tok_mode = (tok_mode == BARE_TOKEN) ? SKIP_SPACES : DISCARD_TO_SPACE;
               content_pos = 2'd0;
            end else begin
               take_content(b);
            end
         end
         default: begin
            if (b == CH_NUL) begin
               emit(CH_NUL, 1'b0, 1'b0, 1'b1);
               clear_parser();
            end else if (b == CH_SPACE) begin
               tok_mode = SKIP_SPACES;
            end
         end
      endcase
   endfunction

   task automatic report_field(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fails++;
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tokenize_byte(req_tdata);
            req_taken = 1'b1;
            words_in <= words_in + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            if (due_results.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h %b %b", $time,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               fails++;
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata !== want.out_byte)
                  report_field("out_byte", want.out_byte, rsp_tdata);
               if (rsp_tuser[0] !== want.byte_valid)
                  report_field("byte_valid", want.byte_valid, rsp_tuser[0]);
               if (rsp_tuser[1] !== want.token_end)
                  report_field("token_end", want.token_end, rsp_tuser[1]);
               if (rsp_tlast !== want.command_end)
                  report_field("command_end", want.command_end, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_in >= 120) begin
         hold_left <= 150;
         hold_done <= 1'b1;
      end
   end

   always @(negedge clock) begin : driver
      logic next_valid;
      logic [7:0] next_data;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         next_data = req_tdata;
         if (req_tvalid && req_taken) next_valid = 1'b0;
         if (!next_valid) begin
            if (req_wait != 0) begin
               req_wait--;
            end else if (pending_bytes.size() != 0) begin
               next_data = pending_bytes.pop_front();
               next_valid = 1'b1;
               if ($urandom_range(0, 19) == 0) req_calm = !req_calm;
               req_wait = req_calm ? 0 : $urandom_range(0, 14);
            end
         end
         req_tvalid <= next_valid;
         req_tdata <= next_data;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 19) == 0) rsp_calm = !rsp_calm;
            rsp_stall = rsp_calm ? 0 : $urandom_range(0, 14);
         end else if (rsp_stall != 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_stall == 0) && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic add_command(string s);
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
      pending_bytes.push_back(CH_NUL);
   endtask

   function automatic logic [7:0] pick_char();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 12) return CH_SPACE;
      if (r < 22) return CH_QUOTE;
      if (r < 32) return CH_BSLASH;
      if (r < 80) return 8'h61 + 8'($urandom_range(0, 25));
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic add_token_body(logic quoted);
      int unsigned n;
      int unsigned r;
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         if (r < 5) begin
            pending_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
         end else if (r < 7) begin
            pending_bytes.push_back(CH_BSLASH);
            pending_bytes.push_back(quoted ? CH_QUOTE : CH_SPACE);
         end else if (r == 7) begin
            pending_bytes.push_back(CH_BSLASH);
         end else if (r == 8 && quoted) begin
            pending_bytes.push_back(CH_SPACE);
         end else begin
            pending_bytes.push_back(8'($urandom_range(1, 255)));
         end
      end
   endtask

   task automatic add_wellformed();
      int unsigned tokens;
      logic quoted;
      repeat ($urandom_range(0, 2)) pending_bytes.push_back(CH_SPACE);
      tokens = $urandom_range(1, 4);
      for (int t = 0; t < tokens; t++) begin
         quoted = $urandom_range(0, 2) == 0;
         if (quoted) begin
            pending_bytes.push_back(CH_QUOTE);
            add_token_body(1'b1);
            pending_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 2)) pending_bytes.push_back(pick_char());
         end else begin
            pending_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
            add_token_body(1'b0);
         end
         if (t + 1 < tokens) repeat ($urandom_range(1, 2)) pending_bytes.push_back(CH_SPACE);
      end
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
         pending_bytes.push_back(CH_SPACE);
      pending_bytes.push_back(CH_NUL);
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 12)) begin
         if ($urandom_range(0, 1) == 0) begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            pending_bytes.push_back(pick_char());
         end
      end
   endtask

   initial begin
      add_command("");
      add_command("  ");
      add_command("\\ a");
      add_command("\"\\\"z");
      add_command("\"a\\\"b\"");
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(CH_BSLASH);
      pending_bytes.push_back(CH_BSLASH);
      pending_bytes.push_back(8'h01);
      pending_bytes.push_back(8'h80);
      pending_bytes.push_back(CH_BSLASH);
      pending_bytes.push_back(CH_NUL);
      while (pending_bytes.size() < STIMULUS_WORDS) begin
         if ($urandom_range(0, 3) != 0) begin
            add_wellformed();
         end else begin
            add_noise();
         end
      end
      pending_bytes.push_back(CH_NUL);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || due_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
